// ===== rtl/seven_segment_field_encoder_defines.svh =====
// Assertion macros used by the checker of the seven-segment field encoder.
// No dependencies; include by bare file name.
`ifndef SEVEN_SEGMENT_FIELD_ENCODER_DEFINES_SVH
`define SEVEN_SEGMENT_FIELD_ENCODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while arst_n is low.
`define SSFE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on clk, disabled while arst_n is low.
`define SSFE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

// ===== rtl/ssfe_pkg.sv =====
// Shared types, codes and lookup tables for the seven-segment field encoder.
// No dependencies; imported by the controller, the datapath and the top level.
package ssfe_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_CHAR
	} state_t;

	localparam logic [1:0] FIELD_ROW0   = 2'd0;
	localparam logic [1:0] FIELD_ROW1   = 2'd1;
	localparam logic [1:0] FIELD_SMALL  = 2'd2;
	localparam logic [1:0] FIELD_UNUSED = 2'd3;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	localparam logic [7:0] SEG_MINUS = 8'h02;
	localparam logic [7:0] SEG_BLANK = 8'h00;
	localparam logic [7:0] SEG_DOT   = 8'h01;

	localparam logic [7:0] SEG_DIGIT [0:9] = '{
		8'hFA, 8'h0A, 8'hBC, 8'h9E, 8'h4E, 8'hD6, 8'hF6, 8'h8A, 8'hFE, 8'hCE
	};

	localparam logic [4:0] POS_ROW0 [0:7] = '{
		5'd16, 5'd17, 5'd18, 5'd19, 5'd12, 5'd13, 5'd14, 5'd15
	};
	localparam logic [4:0] POS_ROW1 [0:7] = '{
		5'd10, 5'd11, 5'd24, 5'd25, 5'd6, 5'd7, 5'd8, 5'd9
	};
	localparam logic [4:0] POS_SMALL [0:7] = '{
		5'd22, 5'd23, 5'd2, 5'd3, 5'd4, 5'd0, 5'd0, 5'd0
	};

	localparam logic [3:0] LEN_ROW   = 4'd8;
	localparam logic [3:0] LEN_SMALL = 4'd5;

	typedef struct packed {
		logic take_start;
		logic take_char;
		logic clr_emit;
		logic chr_emit;
	} cmd_t;

	typedef struct packed {
		logic start_ok;
		logic start_skip;
		logic clr_last;
		logic chr_writes;
		logic out_free;
	} status_t;

	function automatic logic [4:0] pos_addr(input logic [1:0] field, input logic [2:0] idx);
		logic [4:0] addr;
		unique case (field)
			FIELD_ROW1:  addr = POS_ROW1[idx];
			FIELD_SMALL: addr = POS_SMALL[idx];
			default:     addr = POS_ROW0[idx];
		endcase
		return addr;
	endfunction

	function automatic logic [3:0] native_len(input logic [1:0] field);
		logic [3:0] n;
		unique case (field)
			FIELD_SMALL: n = LEN_SMALL;
			default:     n = LEN_ROW;
		endcase
		return n;
	endfunction

	// Returns {is_data, segment code}.
	function automatic logic [8:0] seg_lookup(input logic [7:0] c);
		logic [7:0] diff;
		logic [8:0] res;
		diff = c - CH_ZERO;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			res = {1'b1, SEG_DIGIT[diff[3:0]]};
		end else if (c == CH_MINUS) begin
			res = {1'b1, SEG_MINUS};
		end else if (c == CH_SPACE) begin
			res = {1'b1, SEG_BLANK};
		end else begin
			res = {1'b0, SEG_BLANK};
		end
		return res;
	endfunction

endpackage

// ===== rtl/ssfe_ctrl.sv =====
// Controller state machine of the seven-segment field encoder.
// Depends on ssfe_pkg (state_t, cmd_t, status_t).
module ssfe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ssfe_pkg::status_t sts,
	output ssfe_pkg::cmd_t    cmd
);
	import ssfe_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					priority if (sts.start_ok) begin
						cmd.take_start = 1'b1;
						state_d        = ST_CLEAR;
					end else if (sts.start_skip) begin
						// drop the transaction: no writes, no state change
						state_d = ST_IDLE;
					end else begin
						cmd.take_char = 1'b1;
						state_d       = ST_CHAR;
					end
				end
			end
			ST_CLEAR: begin
				if (sts.out_free) begin
					cmd.clr_emit = 1'b1;
					if (sts.clr_last) begin
						state_d = ST_CHAR;
					end
				end
			end
			ST_CHAR: begin
				if (!sts.chr_writes) begin
					state_d = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.chr_emit = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/ssfe_dp.sv =====
// Datapath of the seven-segment field encoder: field state, clear counter,
// character decode and the output register. Depends on ssfe_pkg.
module ssfe_dp #(
	parameter int MAX_FIELD_DIGITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        char_code,
	input  logic [1:0]        field_sel,
	input  logic              first_char,
	input  ssfe_pkg::cmd_t    cmd,
	output ssfe_pkg::status_t sts,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [4:0]        ram_address,
	output logic [7:0]        ram_data,
	output logic              last
);
	import ssfe_pkg::*;

	localparam logic [3:0] MAX_LEN = 4'(MAX_FIELD_DIGITS);

	logic [7:0] char_q;
	logic [1:0] active_field_q;
	logic [3:0] digit_pos_q;
	logic [7:0] last_written_q;
	logic [2:0] clr_idx_q;
	logic       out_valid_q;
	logic [4:0] ram_address_q;
	logic [7:0] ram_data_q;
	logic       last_q;

	logic [3:0] nat_len;
	logic [3:0] len;
	logic [8:0] seg;
	logic       is_data;
	logic [7:0] code;
	logic       dot_write;
	logic [3:0] prev_pos;
	logic [4:0] chr_addr;
	logic [7:0] chr_data;
	logic       emit;

	always_comb begin
		nat_len   = native_len(active_field_q);
		len       = (MAX_LEN < nat_len) ? MAX_LEN : nat_len;
		seg       = seg_lookup(char_q);
		is_data   = seg[8];
		code      = seg[7:0];
		dot_write = (char_q == CH_DOT) && (digit_pos_q != 4'd0);
		prev_pos  = digit_pos_q - 4'd1;
		chr_addr  = is_data ? pos_addr(active_field_q, digit_pos_q[2:0])
		                    : pos_addr(active_field_q, prev_pos[2:0]);
		chr_data  = is_data ? code : (last_written_q | SEG_DOT);
	end

	assign sts.start_ok   = first_char && (field_sel != FIELD_UNUSED);
	assign sts.start_skip = first_char && (field_sel == FIELD_UNUSED);
	assign sts.clr_last   = ({1'b0, clr_idx_q} == (len - 4'd1));
	assign sts.chr_writes = (digit_pos_q < len) && (is_data || dot_write);
	assign sts.out_free   = !out_valid_q || out_ready;

	assign emit = cmd.clr_emit || cmd.chr_emit;

	// field state and clear counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_field_q <= FIELD_ROW0;
			digit_pos_q    <= 4'd0;
			last_written_q <= 8'd0;
			clr_idx_q      <= 3'd0;
		end else begin
			if (cmd.take_start) begin
				active_field_q <= field_sel;
				digit_pos_q    <= 4'd0;
				last_written_q <= 8'd0;
				clr_idx_q      <= 3'd0;
			end
			if (cmd.clr_emit) begin
				clr_idx_q <= clr_idx_q + 3'd1;
			end
			if (cmd.chr_emit) begin
				last_written_q <= chr_data;
				if (is_data) begin
					digit_pos_q <= digit_pos_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_start || cmd.take_char) begin
			char_q <= char_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_emit) begin
			ram_address_q <= pos_addr(active_field_q, clr_idx_q);
			ram_data_q    <= SEG_BLANK;
			// a clear write closes the transaction when the character adds nothing
			last_q        <= sts.clr_last && !sts.chr_writes;
		end else if (cmd.chr_emit) begin
			ram_address_q <= chr_addr;
			ram_data_q    <= chr_data;
			last_q        <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign ram_address = ram_address_q;
	assign ram_data    = ram_data_q;
	assign last        = last_q;

endmodule

// ===== rtl/seven_segment_field_encoder.sv =====
// Top level of the seven-segment field encoder: controller plus datapath.
// Depends on ssfe_pkg, ssfe_ctrl and ssfe_dp.
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------
//   input   | in_valid / in_ready  | char_code, field_sel, first_char
//   output  | out_valid / out_ready| ram_address, ram_data, last
//
// One transaction at a time. A continuation character is accepted in ST_IDLE,
// then ST_CHAR issues its write, or drops it when there is none.
// A field start is accepted, then ST_CLEAR issues one clear write per field
// position (field length, up to 8) before that same ST_CHAR step, one write
// per cycle through the single output register while the output is not stalled.
// Reset (arst_n low) clears the field state to field 0, position 0.
// Output stalls hold the controller; a new transaction is accepted while the
// last write still sits in the output register.
module seven_segment_field_encoder #(
	parameter int MAX_FIELD_DIGITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic [1:0] field_sel,
	input  logic       first_char,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [4:0] ram_address,
	output logic [7:0] ram_data,
	output logic       last
);
	import ssfe_pkg::*;

	cmd_t    cmd;
	status_t sts;

	ssfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ssfe_dp #(
		.MAX_FIELD_DIGITS (MAX_FIELD_DIGITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_code   (char_code),
		.field_sel   (field_sel),
		.first_char  (first_char),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.ram_address (ram_address),
		.ram_data    (ram_data),
		.last        (last)
	);

endmodule

// ===== rtl/ssfe_checker.sv =====
// Port-level checker for the seven-segment field encoder, bound to the top level.
// Depends on seven_segment_field_encoder_defines.svh and ssfe_pkg.
`include "seven_segment_field_encoder_defines.svh"

module ssfe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] char_code,
	input logic [1:0] field_sel,
	input logic       first_char,
	input logic       out_valid,
	input logic       out_ready,
	input logic [4:0] ram_address,
	input logic [7:0] ram_data,
	input logic       last
);
	import ssfe_pkg::*;

	// a held write keeps its payload
	`SSFE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(ram_address) && $stable(ram_data) && $stable(last))

	// no address beyond the display RAM
	`SSFE_ASSERT_NOW(a_addr_range, out_valid, ram_address <= 5'd25)

	// a continuation character keeps the block busy for its write cycle
	`SSFE_ASSERT_NEXT(a_char_busy, in_valid && in_ready && !first_char, !in_ready)

	// a field start on the unused selector is dropped on the spot
	`SSFE_ASSERT_NEXT(a_skip_idle, in_valid && in_ready && first_char && field_sel == FIELD_UNUSED, in_ready)

endmodule

bind seven_segment_field_encoder ssfe_checker u_ssfe_checker (.*);

// ===== tb/tb_seven_segment_field_encoder.sv =====
// Self-checking testbench for seven_segment_field_encoder: directed and random character
// streams, with a scoreboard that predicts the display RAM writes. Depends on ssfe_pkg and
// the encoder RTL.
`timescale 1ns / 1ps

module tb_seven_segment_field_encoder;
	import ssfe_pkg::*;

	localparam int MAX_FIELD_DIGITS = 8;
	localparam int CYCLE_LIMIT      = 200000;
	localparam int LONG_HOLD        = 300;
	localparam int SETTLE_CYCLES    = 24;
	localparam int RANDOM_ITEMS     = 260;
	localparam int REPORT_LIMIT     = 10;

	localparam logic [7:0] CHR_ZERO  = "0";
	localparam logic [7:0] CHR_NINE  = "9";
	localparam logic [7:0] CHR_DASH  = "-";
	localparam logic [7:0] CHR_SPACE = " ";
	localparam logic [7:0] CHR_DOT   = ".";
	localparam logic [7:0] DP_BIT    = 8'h01;
	localparam logic [7:0] SEG_DASH  = 8'h02;
	localparam logic [7:0] SEG_SPACE = 8'h00;

	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_RANDOM,
		RX_PATTERN
	} rx_mode_t;

	typedef struct packed {
		logic [4:0] addr;
		logic [7:0] data;
		logic       last;
	} ram_write_t;

	class ssfe_scoreboard;
		ram_write_t pending_writes[$];
		logic [3:0] digit_pos;
		logic [1:0] open_field;
		logic [7:0] prev_seg;
		logic [4:0] slot_addr [0:2][0:7];
		logic [7:0] digit_seg [0:9];
		int writes_checked;
		int mismatches;

		function new();
			slot_addr = '{
				'{5'd16, 5'd17, 5'd18, 5'd19, 5'd12, 5'd13, 5'd14, 5'd15},
				'{5'd10, 5'd11, 5'd24, 5'd25, 5'd6, 5'd7, 5'd8, 5'd9},
				'{5'd22, 5'd23, 5'd2, 5'd3, 5'd4, 5'd0, 5'd0, 5'd0}
			};
			digit_seg = '{8'hFA, 8'h0A, 8'hBC, 8'h9E, 8'h4E, 8'hD6, 8'hF6, 8'h8A, 8'hFE, 8'hCE};
			digit_pos = '0;
			open_field = FIELD_ROW0;
			prev_seg = '0;
			writes_checked = 0;
			mismatches = 0;
		endfunction

		function logic [3:0] field_len(logic [1:0] fld);
			int n;
			n = (fld == FIELD_SMALL) ? 5 : 8;
			if (MAX_FIELD_DIGITS < n)
				n = MAX_FIELD_DIGITS;
			return n[3:0];
		endfunction

		function void push_write(logic [4:0] addr, logic [7:0] data);
			ram_write_t w;
			w.addr = addr;
			w.data = data;
			w.last = 1'b0;
			pending_writes.push_back(w);
		endfunction

		// Predict the writes caused by one accepted character.
		function void note_input(logic [7:0] c, logic [1:0] sel, logic start);
			int n;
			int i;
			logic [3:0] len;
			logic [3:0] prev_idx;
			logic [7:0] seg;
			logic is_data;
			ram_write_t w;
			n = 0;
			if (start) begin
				if (sel == FIELD_UNUSED)
					return;
				open_field = sel;
				len = field_len(sel);
				for (i = 0; i < len; i++) begin
					push_write(slot_addr[sel][i], 8'h00);
					n++;
				end
				digit_pos = '0;
				prev_seg = '0;
			end
			len = field_len(open_field);
			if (digit_pos < len) begin
				is_data = 1'b1;
				seg = SEG_SPACE;
				if (c >= CHR_ZERO && c <= CHR_NINE)
					seg = digit_seg[c - CHR_ZERO];
				else if (c == CHR_DASH)
					seg = SEG_DASH;
				else if (c != CHR_SPACE)
					is_data = 1'b0;
				if (is_data) begin
					push_write(slot_addr[open_field][digit_pos[2:0]], seg);
					prev_seg = seg;
					digit_pos = digit_pos + 4'd1;
					n++;
				end else if (c == CHR_DOT && digit_pos != 0) begin
					// the dot lands on the position written just before
					prev_seg = prev_seg | DP_BIT;
					prev_idx = digit_pos - 4'd1;
					push_write(slot_addr[open_field][prev_idx[2:0]], prev_seg);
					n++;
				end
			end
			if (n > 0) begin
				w = pending_writes.pop_back();
				w.last = 1'b1;
				pending_writes.push_back(w);
			end
		endfunction

		function void check_result(logic [4:0] addr, logic [7:0] data, logic fin);
			ram_write_t w;
			writes_checked++;
			if (pending_writes.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected write: addr %0d data %02h last %0d", addr, data, fin);
				return;
			end
			w = pending_writes.pop_front();
			if (addr !== w.addr || data !== w.data || fin !== w.last) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("write mismatch: expected addr %0d data %02h last %0d, got addr %0d data %02h last %0d",
						w.addr, w.data, w.last, addr, data, fin);
			end
		endfunction

		function int pending();
			return pending_writes.size();
		endfunction

		function void report_leftover();
			if (pending_writes.size() != 0) begin
				mismatches++;
				$display("%0d expected writes never arrived", pending_writes.size());
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] char_code = '0;
	logic [1:0] field_sel = '0;
	logic       first_char = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [4:0] ram_address;
	logic [7:0] ram_data;
	logic       last;

	ssfe_scoreboard sb = new();

	rx_mode_t rx_mode = RX_RANDOM;
	logic [7:0] rx_mask = 8'hFF;
	bit hold_request = 1'b0;
	bit gaps_on = 1'b1;
	int burst_left = 0;
	int items_sent = 0;
	int chars_accepted = 0;
	int starts_accepted = 0;
	int dots_accepted = 0;
	int holds_done = 0;
	int cycle_count = 0;

	seven_segment_field_encoder #(
		.MAX_FIELD_DIGITS(MAX_FIELD_DIGITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_code(char_code),
		.field_sel(field_sel),
		.first_char(first_char),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ram_address(ram_address),
		.ram_data(ram_data),
		.last(last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("status: fail");
			$finish;
		end
	end

	// Input transactions are noted before output ones: a write never leaves in the
	// cycle its character is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				sb.note_input(char_code, field_sel, first_char);
				chars_accepted++;
				if (first_char && field_sel != FIELD_UNUSED)
					starts_accepted++;
				if (char_code == CHR_DOT)
					dots_accepted++;
			end
			if (out_valid && out_ready)
				sb.check_result(ram_address, ram_data, last);
		end
	end

	// Receiver: a long hold-off on request, otherwise the current stall mode.
	initial begin
		logic [2:0] rx_tick;
		rx_tick = '0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				holds_done++;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				rx_tick = rx_tick + 3'd1;
				case (rx_mode)
					RX_ALWAYS:  out_ready <= 1'b1;
					RX_PATTERN: out_ready <= rx_mask[rx_tick];
					default:    out_ready <= ($urandom_range(0, 99) < 65);
				endcase
			end
		end
	end

	task automatic send_item(input logic [7:0] c, input logic [1:0] sel, input logic start);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = gaps_on ? $urandom_range(1, 6) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		items_sent++;
		in_valid <= 1'b1;
		char_code <= c;
		field_sel <= sel;
		first_char <= start;
		do @(posedge clk); while (!in_ready);
	endtask

	// Hold the input idle until every predicted write has come out.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] field_char();
		int r;
		r = $urandom_range(0, 19);
		if (r < 13)
			return CHR_ZERO + 8'($urandom_range(0, 9));
		else if (r < 15)
			return CHR_DASH;
		else if (r < 16)
			return CHR_SPACE;
		else if (r < 18)
			return CHR_DOT;
		else if (r < 19)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(8'h21, 8'h7E));
	endfunction

	// One field string: a start, then continuations that may overrun the field.
	task automatic send_field();
		int n;
		int i;
		logic [1:0] sel;
		sel = 2'($urandom_range(0, 2));
		n = $urandom_range(1, 11);
		for (i = 0; i < n; i++) begin
			if (i == 0)
				send_item(field_char(), sel, 1'b1);
			else
				send_item(field_char(), 2'($urandom_range(0, 3)), 1'b0);
		end
	endtask

	task automatic send_noise();
		int n;
		int i;
		logic [1:0] sel;
		logic start;
		n = $urandom_range(1, 3);
		for (i = 0; i < n; i++) begin
			sel = 2'($urandom_range(0, 3));
			start = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 2) == 0) begin
				sel = FIELD_UNUSED;
				start = 1'b1;
			end
			send_item(8'($urandom_range(0, 255)), sel, start);
		end
	endtask

	task automatic send_mixed();
		if ($urandom_range(0, 9) < 8)
			send_field();
		else
			send_noise();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no field opened yet: a leading dot writes nothing, a digit goes to row 0
		send_item(CHR_DOT, FIELD_ROW1, 1'b0);
		send_item("5", FIELD_SMALL, 1'b0);
		// start on the unused selector is dropped whole
		send_item("7", FIELD_UNUSED, 1'b1);
		// start with a dot: clears only
		send_item(CHR_DOT, FIELD_ROW0, 1'b1);
		send_item(CHR_DASH, FIELD_ROW1, 1'b1);
		send_item("0", FIELD_ROW0, 1'b0);
		send_item("1", FIELD_SMALL, 1'b0);
		send_item("2", FIELD_UNUSED, 1'b0);
		send_item(CHR_DOT, FIELD_ROW1, 1'b0);
		send_item("3", FIELD_ROW1, 1'b0);
		send_item("4", FIELD_ROW1, 1'b0);
		send_item("5", FIELD_ROW1, 1'b0);
		send_item("6", FIELD_ROW1, 1'b0);
		// row full: further digits and dots are dropped
		send_item("7", FIELD_ROW1, 1'b0);
		send_item(CHR_DOT, FIELD_ROW1, 1'b0);
		send_item(CHR_SPACE, FIELD_SMALL, 1'b1);
		send_item("8", FIELD_SMALL, 1'b0);
		send_item("9", FIELD_SMALL, 1'b0);
		send_item(CHR_DOT, FIELD_SMALL, 1'b0);
		send_item(8'hFF, FIELD_SMALL, 1'b0);
		send_item(8'h00, FIELD_SMALL, 1'b0);
		send_item(CHR_DASH, FIELD_SMALL, 1'b0);
		send_item("0", FIELD_SMALL, 1'b0);
		send_item("1", FIELD_SMALL, 1'b0);
		// ignored character on a start: the last clear write ends the transaction
		send_item(8'hFF, FIELD_ROW0, 1'b1);
		drain();

		// back-to-back stretch with an always-ready receiver
		rx_mode = RX_ALWAYS;
		gaps_on = 1'b0;
		while (items_sent < 60)
			send_field();

		rx_mode = RX_RANDOM;
		gaps_on = 1'b1;
		while (items_sent < 110)
			send_mixed();

		// flood the input while the receiver holds off
		hold_request = 1'b1;
		gaps_on = 1'b0;
		while (items_sent < 150)
			send_field();
		gaps_on = 1'b1;
		drain();

		rx_mode = RX_PATTERN;
		rx_mask = 8'($urandom_range(1, 255));
		while (items_sent < 200)
			send_mixed();
		rx_mode = RX_RANDOM;
		while (items_sent < RANDOM_ITEMS)
			send_mixed();

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		sb.report_leftover();
		$display("covered %0d characters (%0d field starts, %0d dots) and %0d RAM writes",
			chars_accepted, starts_accepted, dots_accepted, sb.writes_checked);
		$display("receiver long hold-offs: %0d, mismatches: %0d", holds_done, sb.mismatches);
		if (sb.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
